// ----- design/iprg_pkg.sv -----
`default_nettype none
package iprg_pkg;

  // fixed field widths
  localparam int PW    = 7;   // part value / part_total
  localparam int XW    = 6;   // part index
  localparam int CW    = 21;  // counts and ranks
  localparam int NPART = 64;  // depth of the parts store

  // request codes on the input channel
  localparam logic [1:0] REQ_BUILD = 2'd0;
  localparam logic [1:0] REQ_SEEK  = 2'd1;
  localparam logic [1:0] REQ_ADV   = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_BUILT = 2'd1;
  localparam logic [1:0] ST_BAD_RANK  = 2'd2;
  localparam logic [1:0] ST_EXHAUSTED = 2'd3;

  typedef enum logic [1:0] {
    K_BUILD = 2'd0,
    K_SEEK  = 2'd1,
    K_ADV   = 2'd2
  } kind_t;

  // classified request handed from the front to the back
  typedef struct packed {
    kind_t          kind;
    logic [CW-1:0]  start_rank;
    logic [CW-1:0]  end_rank;
  } req_t;

endpackage
`default_nettype wire

// ----- design/iprg_front.sv -----
`default_nettype none
module iprg_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_tvalid,
  output logic                in_tready,
  input  wire  [1:0]          in_tuser,
  input  wire  [47:0]         in_tdata,
  output logic                q_valid,
  input  wire                 q_ready,
  output iprg_pkg::req_t      q_data
);
  import iprg_pkg::*;

  req_t       fifo_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  req_t       cls;
  logic       keep, push, pop;

  // classify the request; the unused code is dropped here
  always_comb begin
    cls.start_rank = in_tdata[CW-1:0];
    cls.end_rank   = in_tdata[2*CW-1:CW];
    keep           = 1'b1;
    unique case (in_tuser)
      REQ_BUILD: cls.kind = K_BUILD;
      REQ_SEEK:  cls.kind = K_SEEK;
      REQ_ADV:   cls.kind = K_ADV;
      default: begin
        cls.kind = K_BUILD;
        keep     = 1'b0;
      end
    endcase
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready && keep;
  assign q_valid   = (cnt_r != 2'd0);
  assign pop       = q_valid && q_ready;
  assign q_data    = fifo_r[rp_r];

  // two-entry queue
  always_ff @(posedge clk) begin
    if (push) fifo_r[wp_r] <= cls;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

// ----- design/iprg_back.sv -----
`default_nettype none
module iprg_back #(
  parameter int MAX_N = 64
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire  [$clog2(MAX_N+2)-1:0]        n_eff,
  input  wire                               q_valid,
  output logic                              q_ready,
  input  iprg_pkg::req_t                    q_data,
  output logic                              out_tvalid,
  input  wire                               out_tready,
  output logic                              out_tlast,
  output logic [1:0]                        out_tuser,
  output logic [39:0]                       out_tdata
);
  import iprg_pkg::*;

  localparam int SIDE = MAX_N + 1;
  localparam int IW   = $clog2(MAX_N + 2);
  localparam int AW   = $clog2(SIDE * SIDE);

  typedef enum logic [12:0] {
    S_IDLE    = 13'b0000000000001,
    S_BLD_RD  = 13'b0000000000010,
    S_BLD_WR  = 13'b0000000000100,
    S_BLD_Z   = 13'b0000000001000,
    S_SK_TOT  = 13'b0000000010000,
    S_SK_RD   = 13'b0000000100000,
    S_SK_CHK  = 13'b0000001000000,
    S_AD_Y    = 13'b0000010000000,
    S_AD_X    = 13'b0000100000000,
    S_AD_LOOP = 13'b0001000000000,
    S_EM_RD   = 13'b0010000000000,
    S_EM_OUT  = 13'b0100000000000,
    S_ONE     = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  // count table and parts store
  logic [CW-1:0] tbl_mem [SIDE*SIDE];
  logic [CW-1:0] tbl_rdata;
  logic [AW-1:0] tbl_raddr, tbl_waddr;
  logic [CW-1:0] tbl_wdata;
  logic          tbl_we;
  logic [PW-1:0] p_mem [NPART];
  logic [PW-1:0] p_rdata, p_wdata;
  logic [XW-1:0] p_raddr, p_waddr;
  logic          p_we;

  // working registers
  logic [IW-1:0] i_r, j_r, rem_r, x_r;
  logic [CW-1:0] prev_r, tot_r, rank_r, end_r, steps_r;
  logic [1:0]    st_r;
  logic [XW-1:0] len_r, last_r, k_r, e_r;
  logic [PW-1:0] ay_r, ax_r;
  logic          tready_r, ract_r;

  logic          can_push, done;
  logic [CW-1:0] bld_v, sk_total;
  logic [IW-1:0] px, rem_new;
  logic          place, place_end, ad_step;

  assign can_push = !out_tvalid || out_tready;
  assign done     = (steps_r == '0) || (last_r == '0);
  assign q_ready  = (state_r == S_IDLE);
  assign sk_total = tbl_rdata;

  // new table entry: 1 in row zero, 0 where j > i, else the entry at column j+1 plus row i-j
  always_comb begin
    if (i_r == '0)      bld_v = CW'(1);
    else if (j_r > i_r) bld_v = '0;
    else                bld_v = prev_r + tbl_rdata;
  end

  // seek: decide the next part
  always_comb begin
    place = 1'b0;
    px    = x_r;
    if (state_r == S_SK_RD && x_r > rem_r) begin
      place = 1'b1;
      px    = rem_r;
    end else if (state_r == S_SK_CHK && rank_r < tbl_rdata) begin
      place = 1'b1;
    end
    rem_new   = rem_r - px;
    place_end = (rem_new == '0) || (len_r == XW'(NPART - 1));
  end

  assign ad_step = (ax_r <= ay_r) && (k_r != XW'(NPART - 1));

  // memory address and write controls
  always_comb begin
    tbl_raddr = AW'(n_eff) * AW'(SIDE) + AW'(1);
    if (state_r == S_BLD_RD)
      tbl_raddr = AW'(i_r - j_r) * AW'(SIDE) + AW'(j_r);
    else if (state_r == S_SK_RD)
      tbl_raddr = AW'(rem_r - x_r) * AW'(SIDE) + AW'(x_r);
    tbl_we    = (state_r == S_BLD_WR) || (state_r == S_BLD_Z);
    tbl_waddr = AW'(i_r) * AW'(SIDE) + ((state_r == S_BLD_Z) ? AW'(0) : AW'(j_r));
    tbl_wdata = (state_r == S_BLD_Z) ? ((i_r == '0) ? CW'(1) : prev_r) : bld_v;

    case (state_r)
      S_AD_Y:            p_raddr = last_r - XW'(1);
      S_EM_RD, S_EM_OUT: p_raddr = e_r;
      default:           p_raddr = last_r;
    endcase
    p_we    = place || (state_r == S_AD_LOOP);
    p_waddr = (state_r == S_AD_LOOP) ? k_r : len_r;
    if (state_r == S_AD_LOOP)
      p_wdata = ad_step ? ax_r : PW'({1'b0, ay_r} + {1'b0, ax_r});
    else
      p_wdata = PW'(px);
  end

  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[tbl_waddr] <= tbl_wdata;
    tbl_rdata <= tbl_mem[tbl_raddr];
    if (p_we) p_mem[p_waddr] <= p_wdata;
    p_rdata <= p_mem[p_raddr];
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          if (q_data.kind == K_BUILD)                     state_nxt = S_BLD_RD;
          else if (!tready_r)                             state_nxt = S_ONE;
          else if (q_data.kind == K_SEEK)                 state_nxt = S_SK_TOT;
          else if (!ract_r || last_r == '0)               state_nxt = S_ONE;
          else                                            state_nxt = S_AD_Y;
        end
      end
      S_BLD_RD:  state_nxt = S_BLD_WR;
      S_BLD_WR:  state_nxt = (j_r == IW'(1)) ? S_BLD_Z : S_BLD_RD;
      S_BLD_Z:   state_nxt = (i_r == IW'(MAX_N)) ? S_ONE : S_BLD_RD;
      S_SK_TOT: begin
        if (rank_r >= sk_total || end_r < rank_r)
          state_nxt = S_ONE;
        else
          state_nxt = S_SK_RD;
      end
      S_SK_RD:   state_nxt = place ? (place_end ? S_EM_RD : S_SK_RD) : S_SK_CHK;
      S_SK_CHK:  state_nxt = (place && place_end) ? S_EM_RD : S_SK_RD;
      S_AD_Y:    state_nxt = S_AD_X;
      S_AD_X:    state_nxt = S_AD_LOOP;
      S_AD_LOOP: state_nxt = ad_step ? S_AD_LOOP : S_EM_RD;
      S_EM_RD:   state_nxt = S_EM_OUT;
      S_EM_OUT: begin
        if (can_push) state_nxt = (e_r == last_r) ? S_IDLE : S_EM_RD;
      end
      S_ONE:     if (can_push) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          rank_r <= q_data.start_rank;
          end_r  <= q_data.end_rank;
          i_r    <= '0;
          j_r    <= IW'(MAX_N);
          prev_r <= '0;
          tot_r  <= '0;
          if (q_data.kind != K_BUILD && !tready_r) st_r <= ST_NOT_BUILT;
          else                                       st_r <= ST_EXHAUSTED;
        end
      end
      S_BLD_WR: begin
        prev_r <= bld_v;
        if (i_r == n_eff && j_r == IW'(1)) tot_r <= bld_v;
        j_r <= j_r - IW'(1);
      end
      S_BLD_Z: begin
        i_r    <= i_r + IW'(1);
        j_r    <= IW'(MAX_N);
        prev_r <= '0;
        st_r   <= ST_OK;
      end
      S_SK_TOT: begin
        st_r    <= ST_BAD_RANK;
        rem_r   <= n_eff;
        x_r     <= IW'(1);
        len_r   <= '0;
        steps_r <= ((end_r > sk_total - CW'(1)) ? sk_total - CW'(1) : end_r)
                   - rank_r;
      end
      S_SK_RD, S_SK_CHK: begin
        if (place) begin
          e_r    <= '0;
          last_r <= len_r;
          len_r  <= len_r + XW'(1);
          rem_r  <= rem_new;
          x_r    <= px;
        end else if (state_r == S_SK_CHK) begin
          rank_r <= rank_r - tbl_rdata;
          x_r    <= x_r + IW'(1);
        end
      end
      S_AD_Y: begin
        ay_r <= (p_rdata != '0) ? p_rdata - PW'(1) : '0;
        k_r  <= last_r - XW'(1);
      end
      S_AD_X: ax_r <= p_rdata + PW'(1);
      S_AD_LOOP: begin
        e_r <= '0;
        if (ad_step) begin
          ay_r <= ay_r - ax_r;
          k_r  <= k_r + XW'(1);
        end else begin
          last_r  <= k_r;
          steps_r <= steps_r - CW'(1);
        end
      end
      S_EM_OUT: if (can_push && e_r != last_r) e_r <= e_r + XW'(1);
      default: ;
    endcase

    // output register
    if ((state_r == S_ONE || state_r == S_EM_OUT) && can_push) begin
      out_tlast <= (state_r == S_ONE) || (e_r == last_r);
      if (state_r == S_ONE) begin
        out_tuser <= st_r;
        out_tdata <= {5'd0, tot_r, 1'b0, XW'(0), PW'(0)};
      end else begin
        out_tuser <= ST_OK;
        out_tdata <= {5'd0, CW'(0), done, e_r, p_rdata};
      end
    end

    if (!rst_n) begin
      state_r    <= S_IDLE;
      out_tvalid <= 1'b0;
      tready_r   <= 1'b0;
      ract_r     <= 1'b0;
      last_r     <= '0;
      steps_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == S_ONE || state_r == S_EM_OUT) && can_push) out_tvalid <= 1'b1;
      else if (out_tready)                                        out_tvalid <= 1'b0;
      if (state_r == S_BLD_Z && i_r == IW'(MAX_N)) tready_r <= 1'b1;
      // range flag
      if (state_r == S_IDLE && q_valid && q_data.kind == K_ADV && tready_r &&
          (!ract_r || last_r == '0))
        ract_r <= 1'b0;
      else if (state_r == S_SK_TOT && (rank_r >= sk_total || end_r < rank_r))
        ract_r <= 1'b0;
      else if (place && place_end)
        ract_r <= 1'b1;
      else if (state_r == S_EM_OUT && can_push && e_r == last_r && done)
        ract_r <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ----- design/integer_partition_range_generator.sv -----
// Build reads, then writes, each count table entry in turn, and writes column zero per row.
// Seek reads the total, then probes the count table (at most about 2*n probes, each a read
// and a check), then reads and outputs each part. Advance rewrites the tail part by part,
// then emits each part. One request is worked on at a time; a two-entry queue takes new
// requests meanwhile. Reset (rst_n low, synchronous) clears the queue, the sequencer and
// the built/range flags; the count table and parts store hold no defined value until written.
`default_nettype none
module integer_partition_range_generator #(
  parameter int MAX_N = 64
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_wr_en,
  input  wire  [6:0]  cfg_wr_data,   // part_total
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [1:0]  in_tuser,      // req_type
  input  wire  [47:0] in_tdata,      // start_rank[20:0], end_rank[41:21]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic        out_tlast,     // last_part
  output logic [1:0]  out_tuser,     // status
  output logic [39:0] out_tdata      // part_value[6:0], part_index[12:7],
                                     // range_done[13], total_count[34:14]
);
  import iprg_pkg::*;

  localparam int IW = $clog2(MAX_N + 2);

  logic [PW-1:0] part_total_r;
  logic [IW-1:0] n_eff;
  logic          q_valid, q_ready;
  req_t          q_data;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n)         part_total_r <= PW'(1);
    else if (cfg_wr_en) part_total_r <= cfg_wr_data;
  end

  // clamp n into 1..MAX_N
  always_comb begin
    if (part_total_r == '0)             n_eff = IW'(1);
    else if (part_total_r > PW'(MAX_N)) n_eff = IW'(MAX_N);
    else                                n_eff = IW'(part_total_r);
  end

  iprg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data)
  );

  iprg_back #(.MAX_N(MAX_N)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .n_eff      (n_eff),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_data     (q_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire
